[rtl/frlk_pkg.sv]
// frlk_pkg: word types, action codes and queue depths for the prefix route lookup.
// Depends on nothing; used by frlk_front, frlk_back, the top level and the bench by scoped name.
`default_nettype none

package frlk_pkg;

    localparam logic [1:0] ACT_HDR  = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_PATH = 2'd2;

    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    localparam int CFG_W = 5;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] route_slot;
        logic [5:0] position;
        logic [7:0] byte_value;
        logic [7:0] method_code;
        logic [6:0] prefix_length;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic       match_found;
        logic [3:0] route_index;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/frlk_ram.sv]
// frlk_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module frlk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/frlk_fifo.sv]
// frlk_fifo: small register queue, used between front and back and for results.
// Depends on nothing.
`default_nettype none

module frlk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/frlk_front.sv]
// frlk_front: accepts input words and drops those that leave no trace
// (unused action, out-of-range table writes, empty non-final path words). Uses frlk_pkg.
`default_nettype none

module frlk_front #(
    parameter int MAX_ROUTES     = 16,
    parameter int MAX_PREFIX_LEN = 64
) (
    input  wire logic              i_push,
    input  wire frlk_pkg::t_in_word i_word,
    input  wire logic              i_q_full,
    output logic                   o_full,
    output logic                   o_q_push,
    output frlk_pkg::t_in_word     o_q_word
);

    logic w_keep;
    logic w_slot_ok;
    logic w_pos_ok;

    assign w_slot_ok = (32'(i_word.route_slot) < MAX_ROUTES);
    assign w_pos_ok  = (32'(i_word.position) < MAX_PREFIX_LEN);

    always_comb begin
        unique case (i_word.action)
            frlk_pkg::ACT_HDR:  w_keep = w_slot_ok;
            frlk_pkg::ACT_BYTE: w_keep = w_slot_ok && w_pos_ok;
            frlk_pkg::ACT_PATH: w_keep = i_word.has_byte || i_word.last;
            default:            w_keep = 1'b0;
        endcase
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && w_keep;
    assign o_q_word = i_word;

endmodule

`default_nettype wire

[rtl/frlk_back.sv]
// frlk_back: table RAM lanes, match flags, path position and the first-match pick.
// Depends on frlk_pkg and frlk_ram.
`default_nettype none

module frlk_back #(
    parameter int MAX_ROUTES     = 16,
    parameter int MAX_PREFIX_LEN = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [frlk_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_q_empty,
    input  wire frlk_pkg::t_in_word         i_q_word,
    output logic                            o_q_pop,
    input  wire logic                       i_res_full,
    output logic                            o_res_push,
    output frlk_pkg::t_out_word             o_res_word
);

    localparam int LW = $clog2(MAX_PREFIX_LEN + 1);
    localparam int AW = $clog2(MAX_PREFIX_LEN);

    logic [frlk_pkg::CFG_W-1:0] r_active_routes;

    logic                       w_adv;
    logic                       w_is_path;
    logic                       w_do_cmp;
    logic [LW-1:0]              r_pos, n_pos;

    logic                       r_b_vld;
    frlk_pkg::t_in_word         r_b_word;
    logic                       r_b_cmp;
    logic [LW-1:0]              r_b_idx;
    logic [LW-1:0]              r_b_pos;
    logic                       w_b_fire;
    logic                       w_b_path;
    logic [LW-1:0]              w_hdr_len;

    logic [7:0]                 w_rdata   [MAX_ROUTES];
    logic [7:0]                 r_method  [MAX_ROUTES];
    logic [LW-1:0]              r_len     [MAX_ROUTES];
    logic [MAX_ROUTES-1:0]      r_flag;
    logic [MAX_ROUTES-1:0]      w_clr;
    logic [MAX_ROUTES-1:0]      w_flag_nx;
    logic [MAX_ROUTES-1:0]      w_cand;

    function automatic int first_set(input logic [MAX_ROUTES-1:0] v);
        int idx;
        idx = 0;
        for (int i = MAX_ROUTES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = i;
            end
        end
        return idx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_routes <= '0;
        end else if (i_cfg_we) begin
            r_active_routes <= i_cfg_wdata;
        end
    end

    // issue stage: RAM access at the queue head
    assign w_adv     = !i_res_full;
    assign o_q_pop   = w_adv && !i_q_empty;
    assign w_is_path = (i_q_word.action == frlk_pkg::ACT_PATH);
    assign w_do_cmp  = w_is_path && i_q_word.has_byte && (r_pos < LW'(MAX_PREFIX_LEN));

    always_comb begin
        n_pos = r_pos;
        if (o_q_pop && w_is_path) begin
            if (i_q_word.last) begin
                n_pos = '0;
            end else if (w_do_cmp) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_b_vld <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (w_adv) begin
                r_b_vld <= o_q_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_word <= i_q_word;
            r_b_cmp  <= w_do_cmp;
            r_b_idx  <= r_pos;
            r_b_pos  <= (w_do_cmp) ? r_pos + 1'b1 : r_pos;
        end
    end

    // compare stage
    assign w_b_fire  = w_adv && r_b_vld;
    assign w_b_path  = (r_b_word.action == frlk_pkg::ACT_PATH);
    assign w_hdr_len = (32'(r_b_word.prefix_length) > MAX_PREFIX_LEN) ?
                       LW'(MAX_PREFIX_LEN) : LW'(r_b_word.prefix_length);

    for (genvar s = 0; s < MAX_ROUTES; s++) begin : g_lane
        logic w_we;
        logic w_hdr_we;
        logic w_in_limit;

        assign w_we     = o_q_pop && (i_q_word.action == frlk_pkg::ACT_BYTE) &&
                          (32'(i_q_word.route_slot) == s);
        assign w_hdr_we = w_b_fire && (r_b_word.action == frlk_pkg::ACT_HDR) &&
                          (32'(r_b_word.route_slot) == s);
        assign w_in_limit = (32'(r_active_routes) > s);

        frlk_ram #(
            .WIDTH (8),
            .DEPTH (MAX_PREFIX_LEN)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (AW'(i_q_word.position)),
            .i_wdata (i_q_word.byte_value),
            .i_re    (o_q_pop && w_do_cmp),
            .i_raddr (r_pos[AW-1:0]),
            .o_rdata (w_rdata[s])
        );

        assign w_clr[s]     = r_b_cmp && (r_b_idx < r_len[s]) &&
                              (w_rdata[s] != r_b_word.byte_value);
        assign w_flag_nx[s] = r_flag[s] && !w_clr[s];
        assign w_cand[s]    = w_in_limit && w_flag_nx[s] && (r_b_pos >= r_len[s]) &&
                              ((r_method[s] == 8'd0) ||
                               (r_method[s] == r_b_word.method_code));

        always_ff @(posedge i_clk) begin
            if (w_hdr_we) begin
                r_method[s] <= r_b_word.method_code;
                r_len[s]    <= w_hdr_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '1;
        end else if (w_b_fire && w_b_path) begin
            r_flag <= r_b_word.last ? '1 : w_flag_nx;
        end
    end

    assign o_res_push             = w_b_fire && w_b_path && r_b_word.last;
    assign o_res_word.match_found = |w_cand;
    assign o_res_word.route_index = 4'(first_set(w_cand));

    a_rearm_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (&r_flag))
        else $error("match flags not rearmed after a result");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_pos_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && w_is_path && i_q_word.last) |=> (r_pos == '0))
        else $error("path position not cleared after final word");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && r_b_vld) |=> (r_b_vld && $stable(r_b_word) && $stable(r_b_pos)))
        else $error("compare stage moved while stalled");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && w_b_path) |-> (r_b_pos <= LW'(MAX_PREFIX_LEN)))
        else $error("path position beyond saturation");

endmodule

`default_nettype wire

[rtl/first_match_prefix_route_lookup.sv]
// first_match_prefix_route_lookup: top level of the first-match prefix route lookup.
// Depends on frlk_pkg, frlk_front, frlk_fifo and frlk_back.
//
// Input channel: drive i_in_word with push high; the word is taken at a clock
// edge where push is high and full is low. Header and prefix-byte words load
// the route table, path words stream a request path one byte per word.
// Result channel: while empty is low, o_out_word carries the oldest result;
// it is taken at an edge where pop is high. One result follows each path word
// with last set.
// Configuration: i_cfg_we writes i_cfg_wdata into the active route count at
// once; write only while no path word is in flight.
// Throughput: one word per cycle while the result queue is not full, set by
// the single RAM read per lane and the compare stage.
// A result passes from its final path word through the command queue, issue
// stage, compare stage and result queue before it is visible.
// Stall: when the result queue is full the back end holds; the command queue
// then fills and full rises. Nothing is lost.
// Reset: i_rst_n low for one edge empties both queues, clears the active route
// count and the path position and rearms all match flags. Table contents are
// not cleared and must be written before use.
`default_nettype none

module first_match_prefix_route_lookup #(
    parameter int MAX_ROUTES     = 16,
    parameter int MAX_PREFIX_LEN = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [frlk_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire frlk_pkg::t_in_word         i_in_word,
    output logic                            empty,
    input  wire logic                       pop,
    output frlk_pkg::t_out_word             o_out_word
);

    logic                cq_push, cq_pop, cq_full, cq_empty;
    frlk_pkg::t_in_word  cq_wword, cq_rword;
    logic                rq_push, rq_full;
    frlk_pkg::t_out_word rq_wword;

    frlk_front #(
        .MAX_ROUTES     (MAX_ROUTES),
        .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
    ) u_front (
        .i_push   (push),
        .i_word   (i_in_word),
        .i_q_full (cq_full),
        .o_full   (full),
        .o_q_push (cq_push),
        .o_q_word (cq_wword)
    );

    frlk_fifo #(
        .WIDTH ($bits(frlk_pkg::t_in_word)),
        .DEPTH (frlk_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_wdata (cq_wword),
        .i_pop   (cq_pop),
        .o_rdata (cq_rword),
        .o_full  (cq_full),
        .o_empty (cq_empty)
    );

    frlk_back #(
        .MAX_ROUTES     (MAX_ROUTES),
        .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (cq_empty),
        .i_q_word    (cq_rword),
        .o_q_pop     (cq_pop),
        .i_res_full  (rq_full),
        .o_res_push  (rq_push),
        .o_res_word  (rq_wword)
    );

    frlk_fifo #(
        .WIDTH ($bits(frlk_pkg::t_out_word)),
        .DEPTH (frlk_pkg::RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_wdata (rq_wword),
        .i_pop   (pop),
        .o_rdata (o_out_word),
        .o_full  (rq_full),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

[dv/tb.sv]
// tb: self-checking bench for first_match_prefix_route_lookup: table load, directed steps,
// then random phases per active route count; results checked by in-bench predictor or set wants.
// Depends on frlk_pkg and the first_match_prefix_route_lookup RTL.
`default_nettype none

module tb;

    localparam int ROUTES        = 16;
    localparam int PREFIX_MAX    = 64;
    localparam int SHORT_BYTES   = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        bit                  is_cfg;
        logic [4:0]          count;
        frlk_pkg::t_in_word  w;
        bit                  typed;
        frlk_pkg::t_out_word want;
    } t_step;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [frlk_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                       push        = 1'b0;
    logic                       pop         = 1'b0;
    frlk_pkg::t_in_word         i_in_word   = '0;
    logic                       full;
    logic                       empty;
    frlk_pkg::t_out_word        o_out_word;

    // predictor state
    logic [7:0] r_meth  [ROUTES];
    logic [6:0] r_len   [ROUTES];
    logic [7:0] r_bytes [ROUTES][PREFIX_MAX];
    bit         alive   [ROUTES];
    logic [6:0] path_pos;
    logic [4:0] active_routes;

    frlk_pkg::t_out_word pending_results[$];
    t_step               plan[$];
    int                  fails  = 0;
    int                  cycles = 0;
    bit                  calm   = 1'b0;

    first_match_prefix_route_lookup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void rearm_paths();
        for (int s = 0; s < ROUTES; s++) alive[s] = 1'b1;
        path_pos = '0;
    endfunction

    function automatic void route_predict(input frlk_pkg::t_in_word w, output bit got,
                                          output frlk_pkg::t_out_word r);
        int lim;
        got = 1'b0;
        r   = '0;
        case (w.action)
            frlk_pkg::ACT_HDR: begin
                r_meth[w.route_slot] = w.method_code;
                r_len[w.route_slot]  = (w.prefix_length > 7'(PREFIX_MAX)) ?
                                       7'(PREFIX_MAX) : w.prefix_length;
            end
            frlk_pkg::ACT_BYTE: r_bytes[w.route_slot][w.position] = w.byte_value;
            frlk_pkg::ACT_PATH: begin
                if (w.has_byte && path_pos < 7'(PREFIX_MAX)) begin
                    for (int s = 0; s < ROUTES; s++)
                        if (path_pos < r_len[s] && r_bytes[s][path_pos[5:0]] != w.byte_value)
                            alive[s] = 1'b0;
                    path_pos = path_pos + 7'd1;
                end
                if (w.last) begin
                    got = 1'b1;
                    lim = (active_routes > 5'(ROUTES)) ? ROUTES : int'(active_routes);
                    for (int s = 0; s < lim && !r.match_found; s++) begin
                        if ((r_meth[s] == 8'd0 || r_meth[s] == w.method_code) &&
                            path_pos >= r_len[s] && alive[s]) begin
                            r.match_found = 1'b1;
                            r.route_index = 4'(s);
                        end
                    end
                    rearm_paths();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic frlk_pkg::t_in_word rand_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return frlk_pkg::t_in_word'(raw[$bits(frlk_pkg::t_in_word)-1:0]);
    endfunction

    function automatic logic [7:0] pick_method();
        case ($urandom_range(2))
            0:       return 8'd0;
            1:       return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // only these slots get long prefixes; all their bytes are loaded
    function automatic bit long_slot(input logic [3:0] slot);
        return (slot < 4'd4) || (slot == 4'd15);
    endfunction

    function automatic logic [6:0] pick_len(input logic [3:0] slot);
        if (long_slot(slot) && $urandom_range(7) == 0) return 7'($urandom_range(11, 127));
        return 7'($urandom_range(10));
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(4))
            0:       return 8'h2f;
            1:       return 8'h61;
            2:       return 8'h62;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic frlk_pkg::t_in_word mk(input logic [1:0] act, input logic [3:0] slot,
                                              input logic [5:0] pos, input logic [7:0] val,
                                              input logic [7:0] meth, input logic [6:0] plen,
                                              input logic hb, input logic lst);
        return '{act, slot, pos, val, meth, plen, hb, lst};
    endfunction

    task automatic send_word(input frlk_pkg::t_in_word w, input bit typed = 1'b0,
                             input frlk_pkg::t_out_word want = '0);
        bit                  got;
        frlk_pkg::t_out_word r;
        while (!calm && $urandom_range(99) < 35) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        route_predict(w, got, r);
        if (got) pending_results.push_back(typed ? want : r);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_active_routes(input logic [4:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        active_routes = v;
    endtask

    task automatic send_table_edit();
        frlk_pkg::t_in_word w;
        w = rand_word();
        if ($urandom_range(1) == 0) begin
            w.action        = frlk_pkg::ACT_HDR;
            w.method_code   = pick_method();
            w.prefix_length = pick_len(w.route_slot);
        end else begin
            w.action     = frlk_pkg::ACT_BYTE;
            w.byte_value = pick_char();
        end
        send_word(w);
    endtask

    // mostly a copy of one route's prefix, with odd bytes, gaps and edits mixed in
    task automatic stream_path(output int n);
        frlk_pkg::t_in_word w;
        int                 t, len;
        logic [7:0]         meth;
        n = 0;
        t = $urandom_range(ROUTES - 1);
        case ($urandom_range(9))
            0:       len = $urandom_range(PREFIX_MAX, PREFIX_MAX + 8);
            1:       len = (r_len[t] > 0) ? int'(r_len[t]) - 1 : 0;
            default: len = int'(r_len[t]) + $urandom_range(2);
        endcase
        meth = ($urandom_range(4) == 0 || r_meth[t] == 8'd0) ? pick_method() : r_meth[t];
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(39) == 0) begin
                send_table_edit();
                n++;
            end
            if ($urandom_range(11) == 0) begin
                w          = rand_word();
                w.action   = frlk_pkg::ACT_PATH;
                w.has_byte = 1'b0;
                w.last     = 1'b0;
                send_word(w);
            end
            w            = rand_word();
            w.action     = frlk_pkg::ACT_PATH;
            w.has_byte   = 1'b1;
            w.byte_value = (i < int'(r_len[t])) ? r_bytes[t][i] : pick_char();
            if ($urandom_range(14) == 0) w.byte_value = 8'($urandom_range(255));
            w.last       = (i == len - 1) && ($urandom_range(3) != 0);
            if (w.last) w.method_code = meth;
            send_word(w);
            n++;
        end
        if (len == 0 || !w.last) begin
            w             = rand_word();
            w.action      = frlk_pkg::ACT_PATH;
            w.has_byte    = 1'b0;
            w.last        = 1'b1;
            w.method_code = meth;
            send_word(w);
            n++;
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        frlk_pkg::t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: match_found %0d route_index %0d",
                       o_out_word.match_found, o_out_word.route_index);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.match_found !== want.match_found) begin
                    $error("match_found: expected %0d, actual %0d",
                           want.match_found, o_out_word.match_found);
                    fails++;
                end
                if (o_out_word.route_index !== want.route_index) begin
                    $error("route_index: expected %0d, actual %0d",
                           want.route_index, o_out_word.route_index);
                    fails++;
                end
            end
        end
        pop <= calm || ($urandom_range(99) >= 35);
    end

    initial begin
        frlk_pkg::t_in_word w;
        int                 done, n;
        logic [4:0]         counts [PHASES];

        counts = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd16, 5'd1, 5'd9};
        counts[PHASES-1] = 5'($urandom_range(31));

        // directed steps; count rows are register writes between them
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 0, 8'h00, 0, 0, 1), 1, 5'b0_0000});
        plan.push_back('{1, 5'd16, '0, 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_HDR, 0, 0, 0, 8'h00, 7'd0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 0, 8'hff, 0, 0, 1), 1, 5'b1_0000});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_HDR, 0, 0, 0, 8'hff, 7'd127, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_HDR, 1, 0, 0, 8'h01, 7'd1, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_BYTE, 1, 0, 8'h2f, 0, 0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 8'h2f, 8'h01, 0, 1, 1), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 8'h2f, 8'h02, 0, 1, 1), 0, '0});
        plan.push_back('{0, 5'd0, mk(ACT_NONE, 15, 63, 8'hff, 8'hff, 7'd127, 1, 1), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 0, 8'h00, 0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 8'h00, 8'h00, 0, 1, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_HDR, 2, 0, 0, 8'h00, 7'd2, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_BYTE, 2, 1, 8'h55, 0, 0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_BYTE, 2, 0, 8'h11, 0, 0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 8'h55, 8'h80, 0, 1, 1), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_BYTE, 15, 63, 8'hff, 0, 0, 0, 0), 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_HDR, 15, 0, 0, 8'h80, 7'd64, 0, 0), 0, '0});
        plan.push_back('{1, 5'd1, '0, 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 8'h2f, 8'h01, 0, 1, 1), 1, 5'b0_0000});
        plan.push_back('{1, 5'd31, '0, 0, '0});
        plan.push_back('{0, 5'd0, mk(frlk_pkg::ACT_PATH, 0, 0, 0, 8'h00, 0, 0, 1), 0, '0});

        for (int s = 0; s < ROUTES; s++) begin
            r_meth[s] = '0;
            r_len[s]  = '0;
            for (int p = 0; p < PREFIX_MAX; p++) r_bytes[s][p] = '0;
        end
        rearm_paths();
        active_routes = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every header, and every prefix byte a header length can reach, written first
        for (int s = 0; s < ROUTES; s++) begin
            w               = rand_word();
            w.action        = frlk_pkg::ACT_HDR;
            w.route_slot    = 4'(s);
            w.method_code   = pick_method();
            w.prefix_length = pick_len(4'(s));
            send_word(w);
            for (int p = 0; p < (long_slot(4'(s)) ? PREFIX_MAX : SHORT_BYTES); p++) begin
                w            = rand_word();
                w.action     = frlk_pkg::ACT_BYTE;
                w.route_slot = 4'(s);
                w.position   = 6'(p);
                w.byte_value = pick_char();
                send_word(w);
            end
        end

        foreach (plan[i]) begin
            if (plan[i].is_cfg) load_active_routes(plan[i].count);
            else send_word(plan[i].w, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            load_active_routes(counts[ph]);
            calm = (ph == 3);
            done = 0;
            while (done < PHASE_WORDS) begin
                case ($urandom_range(19))
                    0, 1, 2: begin
                        send_table_edit();
                        done++;
                    end
                    3: begin
                        w        = rand_word();
                        w.action = ACT_NONE;
                        send_word(w);
                    end
                    default: begin
                        stream_path(n);
                        done += n;
                    end
                endcase
            end
        end
        calm = 1'b0;

        settle();
        if (fails == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[first_match_prefix_route_lookup.f]
rtl/frlk_pkg.sv
rtl/frlk_ram.sv
rtl/frlk_fifo.sv
rtl/frlk_front.sv
rtl/frlk_back.sv
rtl/first_match_prefix_route_lookup.sv
dv/tb.sv
